>>> sv/sha1md_pkg.sv
package sha1md_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [1:0] GRP_CH  = 2'd0;
  localparam logic [1:0] GRP_PAR = 2'd1;
  localparam logic [1:0] GRP_MAJ = 2'd2;
  localparam logic [1:0] GRP_LST = 2'd3;

  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      default: v = 32'hC3D2E1F0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [1:0] grp);
    logic [31:0] v;
    unique case (grp)
      GRP_CH:  v = 32'h5A827999;
      GRP_PAR: v = 32'h6ED9EBA1;
      GRP_MAJ: v = 32'h8F1BBCDC;
      default: v = 32'hCA62C1D6;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] v;
    unique case (grp)
      GRP_CH:  v = (b & c) | (~b & d);
      GRP_MAJ: v = (b & c) | (b & d) | (c & d);
      default: v = b ^ c ^ d;
    endcase
    return v;
  endfunction

endpackage

>>> sv/sha1_message_digest_unit.sv
// SHA-1 digest engine taking one message byte per item. While idle (busy low) a byte is
// taken every cycle and packed big-endian into a 16-word block memory. The 64th byte of a
// block starts a compression that holds busy while it reads the chaining memory into
// a..e, runs 80 rounds at one round per cycle, and does a read-add-write pass on the
// chaining memory. An item with end_of_message set then feeds padding bytes one per cycle
// outside the compressions (9 to 72 of them), running one or two further compressions, and
// reads the digest back: H0..H4 appear on out_item on consecutive cycles, each marked by
// out_valid for one cycle only, last_word on H4.
// There is no back-pressure on the result side, so the receiver must take every word as
// it appears. Afterwards the chaining words, bit count and block fill are back at their
// start values.
module sha1_message_digest_unit
  import sha1md_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  typedef enum logic [2:0] {ST_IDLE, ST_LOADH, ST_ROUND, ST_ADDH, ST_PAD, ST_OUT} state_t;
  typedef enum logic [1:0] {PH_MARK, PH_ZERO, PH_LEN} pad_ph_t;

  state_t      state_r;
  pad_ph_t     ph_r;
  logic [5:0]  pos_r;
  logic [63:0] bits_r;
  logic [6:0]  cnt_r;
  logic [2:0]  len_ix_r;
  logic        pad_act_r;
  logic        fin_r;
  logic [4:0]  hv_r;
  logic        out_valid_r;
  out_item_t   out_item_r;

  logic [23:0] acc_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] win_r [16];

  logic [31:0] blk_mem [16];
  logic [31:0] blk_q_r;
  logic [31:0] ch_mem [5];
  logic [31:0] ch_q_r;
  logic [2:0]  ch_ix_r;
  logic        ch_hv_r;

  logic        accept;
  logic        put_en;
  logic [7:0]  put_b;
  logic        blk_fill;
  logic [3:0]  blk_ra;
  logic [2:0]  ch_ra;
  logic [2:0]  ch_wa;
  logic        ch_we;
  logic [31:0] ch_rd;
  logic [1:0]  grp;
  logic [31:0] wt;
  logic [31:0] tmp;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // byte insertion path, shared by message bytes and padding
  always_comb begin
    put_en = 1'b0;
    put_b  = '0;
    if (accept && in_item.has_byte) begin
      put_en = 1'b1;
      put_b  = in_item.data_byte;
    end else if (state_r == ST_PAD) begin
      put_en = 1'b1;
      unique case (ph_r)
        PH_MARK: put_b = PAD_MARK;
        PH_ZERO: put_b = '0;
        PH_LEN:  put_b = bits_r[{len_ix_r, 3'b000} +: 8];
        default: put_b = '0;
      endcase
    end
  end

  assign blk_fill = put_en && (pos_r == 6'd63);

  // block memory: one word written per four bytes, read in order during rounds 0..15
  assign blk_ra = (state_r == ST_ROUND) ? (cnt_r[3:0] + 4'd1) : 4'd0;

  always_ff @(posedge clk) begin
    if (put_en && (pos_r[1:0] == 2'b11)) begin
      blk_mem[pos_r[5:2]] <= {acc_r, put_b};
    end
    blk_q_r <= blk_mem[blk_ra];
  end

  // chaining memory; an entry never written since the last digest reads as its IV
  assign ch_ra = (cnt_r < 7'd5) ? cnt_r[2:0] : 3'd0;
  assign ch_wa = cnt_r[2:0] - 3'd1;
  assign ch_we = (state_r == ST_ADDH) && (cnt_r != 7'd0);
  assign ch_rd = ch_hv_r ? ch_q_r : h_init(ch_ix_r);

  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch_mem[ch_wa] <= ch_rd + a_r;
    end
    ch_q_r  <= ch_mem[ch_ra];
    ch_ix_r <= ch_ra;
    ch_hv_r <= hv_r[ch_ra];
  end

  // one SHA-1 round
  always_comb begin
    if (cnt_r < 7'd20) begin
      grp = GRP_CH;
    end else if (cnt_r < 7'd40) begin
      grp = GRP_PAR;
    end else if (cnt_r < 7'd60) begin
      grp = GRP_MAJ;
    end else begin
      grp = GRP_LST;
    end
    if (cnt_r < 7'd16) begin
      wt = blk_q_r;
    end else begin
      wt = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
      wt = {wt[30:0], wt[31]};
    end
    tmp = {a_r[26:0], a_r[31:27]} + round_f(grp, b_r, c_r, d_r) + e_r + wt + round_k(grp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= PH_MARK;
      pos_r       <= '0;
      bits_r      <= '0;
      cnt_r       <= '0;
      len_ix_r    <= 3'd7;
      pad_act_r   <= 1'b0;
      fin_r       <= 1'b0;
      hv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_OUT) && (cnt_r != 7'd0);
      if (put_en) begin
        pos_r <= pos_r + 6'd1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_item.has_byte) begin
              bits_r <= bits_r + 64'd8;
            end
            if (in_item.end_of_message) begin
              pad_act_r <= 1'b1;
              ph_r      <= PH_MARK;
              len_ix_r  <= 3'd7;
            end
            if (blk_fill) begin
              state_r <= ST_LOADH;
              cnt_r   <= '0;
            end else if (in_item.end_of_message) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          unique case (ph_r)
            PH_MARK: ph_r <= (pos_r == 6'd55) ? PH_LEN : PH_ZERO;
            PH_ZERO: if (pos_r == 6'd55) begin
              ph_r <= PH_LEN;
            end
            PH_LEN: begin
              len_ix_r <= len_ix_r - 3'd1;
              if (len_ix_r == 3'd0) begin
                fin_r <= 1'b1;
              end
            end
            default: ph_r <= PH_MARK;
          endcase
          if (blk_fill) begin
            state_r <= ST_LOADH;
            cnt_r   <= '0;
          end
        end
        ST_LOADH: begin
          if (cnt_r == 7'd5) begin
            state_r <= ST_ROUND;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_ROUND: begin
          if (cnt_r == 7'd79) begin
            state_r <= ST_ADDH;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_ADDH: begin
          if (cnt_r != 7'd0) begin
            hv_r[ch_wa] <= 1'b1;
          end
          if (cnt_r == 7'd5) begin
            cnt_r <= '0;
            if (fin_r) begin
              state_r <= ST_OUT;
            end else if (pad_act_r) begin
              state_r <= ST_PAD;
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        ST_OUT: begin
          if (cnt_r == 7'd5) begin
            // drop the chain back to the IVs for the next message
            state_r   <= ST_IDLE;
            cnt_r     <= '0;
            hv_r      <= '0;
            bits_r    <= '0;
            pad_act_r <= 1'b0;
            fin_r     <= 1'b0;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      acc_r <= {acc_r[15:0], put_b};
    end
    unique case (state_r)
      ST_LOADH: if (cnt_r != 7'd0) begin
        a_r <= b_r;
        b_r <= c_r;
        c_r <= d_r;
        d_r <= e_r;
        e_r <= ch_rd;
      end
      ST_ROUND: begin
        e_r <= d_r;
        d_r <= c_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        b_r <= a_r;
        a_r <= tmp;
        for (int i = 0; i < 15; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[15] <= wt;
      end
      ST_ADDH: if (cnt_r != 7'd0) begin
        a_r <= b_r;
        b_r <= c_r;
        c_r <= d_r;
        d_r <= e_r;
      end
      ST_OUT: if (cnt_r != 7'd0) begin
        out_item_r.digest_word <= ch_rd;
        out_item_r.word_index  <= cnt_r[2:0] - 3'd1;
        out_item_r.last_word   <= (cnt_r == 7'd5);
      end
      default: ;
    endcase
  end

  a_words_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_word |=> out_valid)
    else $error("digest words not on consecutive cycles");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.last_word == (out_item.word_index == 3'd4)))
    else $error("last_word does not match word_index");

  a_fill_comp: assert property (@(posedge clk) disable iff (!rst_n)
    blk_fill |=> (state_r == ST_LOADH))
    else $error("full block did not start a compression");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) && (cnt_r == 7'd79) |=> (state_r == ST_ADDH))
    else $error("round 79 not followed by chain update");

  a_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (fin_r && (pos_r == 6'd0)))
    else $error("digest read before padding finished");

endmodule
